>>> src/mavt_pkg.sv
// ----------------------------------------------------------------------------
// Multi-turn angle and velocity tracker package
// Shared widths, quadrant codes, sequencer states and the request type of the
// shared arithmetic unit.
// ----------------------------------------------------------------------------
package mavt_pkg;

	localparam int ANGLE_BITS   = 12;
	localparam int TURN_BITS    = 16;
	localparam int POS_BITS     = ANGLE_BITS + TURN_BITS;
	localparam int TPS_BITS     = 30;
	localparam int ELAPSED_BITS = 20;
	localparam int VEL_BITS     = 32;
	localparam int QUAD_BITS    = 3;
	localparam int MAG_BITS     = POS_BITS;
	localparam int PROD_BITS    = MAG_BITS + TPS_BITS;
	localparam int MUL_STEPS    = TPS_BITS;
	localparam int DIV_STEPS    = VEL_BITS - 1;
	localparam int CNT_BITS     = $clog2(DIV_STEPS);
	localparam int ALU_BITS     = MAG_BITS + 2;

	localparam int S_TDATA_BITS = ((ANGLE_BITS + ELAPSED_BITS + 7) / 8) * 8;
	localparam int M_FIELD_BITS = POS_BITS + TURN_BITS + QUAD_BITS + VEL_BITS;
	localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

	localparam logic [TPS_BITS-1:0] TPS_RESET = TPS_BITS'(1000000);

	localparam logic [ANGLE_BITS:0] QUARTER_1 = (ANGLE_BITS + 1)'(1 << (ANGLE_BITS - 2));
	localparam logic [ANGLE_BITS:0] QUARTER_2 = (ANGLE_BITS + 1)'(2 << (ANGLE_BITS - 2));
	localparam logic [ANGLE_BITS:0] QUARTER_3 = (ANGLE_BITS + 1)'(3 << (ANGLE_BITS - 2));

	localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS - 1){1'b1}}};
	localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS - 1){1'b0}}};

	localparam logic signed [VEL_BITS-1:0] VEL_MAX = {1'b0, {(VEL_BITS - 1){1'b1}}};
	localparam logic signed [VEL_BITS-1:0] VEL_MIN = {1'b1, {(VEL_BITS - 1){1'b0}}};

	typedef logic [QUAD_BITS-1:0] quad_t;

	localparam quad_t QUAD_NONE = 3'd0;
	localparam quad_t QUAD_1    = 3'd1;
	localparam quad_t QUAD_2    = 3'd2;
	localparam quad_t QUAD_3    = 3'd3;
	localparam quad_t QUAD_4    = 3'd4;

	localparam logic CMD_ZERO   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_ABS,
		ST_MUL,
		ST_CHK,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                sub;
		logic [ALU_BITS-1:0] a;
		logic [ALU_BITS-1:0] b;
	} alu_req_t;

endpackage

>>> src/multiturn_angle_velocity_tracker_unit.sv
// ----------------------------------------------------------------------------
// Multi-turn angle and velocity tracker
// Unwraps absolute angle samples into a multi-turn position and computes the
// velocity with one shared add/subtract unit under a small sequencer.
// A sample with nonzero elapsed ticks passes update, sign, serial multiply,
// range check, serial divide and output steps; a saturated velocity skips the
// divide. A zero command or a sample with zero elapsed ticks goes from update
// straight to output. The block takes no new request until it is back in idle,
// so the serial multiply and divide on the shared unit set the pace; it waits
// in the output step while the output is held. Reset clears the sequencer and
// tracking state but not the datapath registers; ticks_per_second is 1000000.
// ----------------------------------------------------------------------------
module multiturn_angle_velocity_tracker_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mavt_pkg::TPS_BITS-1:0]         cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// raw_angle [11:0], elapsed_ticks [31:12]
	input  logic [mavt_pkg::S_TDATA_BITS-1:0]     s_tdata,
	// command
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// total_position [27:0], turn_count [43:28], quadrant_now [46:44],
	// velocity [78:47], zero padding [79]
	output logic [mavt_pkg::M_TDATA_BITS-1:0]     m_tdata,
	// velocity_valid
	output logic                                  m_tuser
);
	import mavt_pkg::*;

	state_t                        state_q, state_d;
	logic [TPS_BITS-1:0]           tps_q;
	logic [ANGLE_BITS-1:0]         zero_offset_q;
	quad_t                         last_quad_q;
	logic signed [TURN_BITS-1:0]   turns_q;
	logic signed [POS_BITS-1:0]    last_pos_q;
	logic [CNT_BITS-1:0]           cnt_q;
	logic                          m_tvalid_q;

	logic                          cmd_q;
	logic [ANGLE_BITS-1:0]         raw_q;
	logic [ELAPSED_BITS-1:0]       elapsed_q;
	logic signed [POS_BITS:0]      delta_q;
	logic                          neg_q;
	logic [MAG_BITS-1:0]           mag_q;
	logic [PROD_BITS-1:0]          prod_q;
	logic [ELAPSED_BITS-1:0]       rem_q;
	logic                          ovf_q;
	logic                          vvalid_q;

	logic signed [POS_BITS-1:0]    out_pos_q;
	logic signed [TURN_BITS-1:0]   out_turns_q;
	quad_t                         out_quad_q;
	logic signed [VEL_BITS-1:0]    out_vel_q;
	logic                          out_vvalid_q;

	logic                          in_take;
	logic                          out_free;
	logic                          out_load;
	logic                          has_velocity;
	logic [ANGLE_BITS-1:0]         corr;
	quad_t                         quad_new;
	logic signed [TURN_BITS-1:0]   turns_new;
	logic signed [POS_BITS-1:0]    pos_new;
	logic signed [POS_BITS:0]      delta_new;
	logic [POS_BITS:0]             delta_neg;
	alu_req_t                      alu_req;
	logic [ALU_BITS:0]             alu_sum;
	logic                          alu_carry;
	logic [MAG_BITS:0]             mul_hi;
	logic                          div_bit;
	logic [VEL_BITS-1:0]           quot_ext;
	logic signed [VEL_BITS-1:0]    vel_fin;

	assign cfg_ready = 1'b1;
	assign in_take   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = out_vvalid_q;
	assign m_tdata   = M_TDATA_BITS'({out_vel_q, out_quad_q, out_turns_q, out_pos_q});

	assign has_velocity = (cmd_q == CMD_SAMPLE) && (elapsed_q != '0);

	// Angle unwrap and position update.
	always_comb begin
		corr = raw_q - zero_offset_q;
		if ({1'b0, corr} <= QUARTER_1) begin
			quad_new = QUAD_1;
		end else if ({1'b0, corr} <= QUARTER_2) begin
			quad_new = QUAD_2;
		end else if ({1'b0, corr} <= QUARTER_3) begin
			quad_new = QUAD_3;
		end else begin
			quad_new = QUAD_4;
		end
		turns_new = turns_q;
		if (quad_new == QUAD_1 && last_quad_q == QUAD_4 && turns_q != TURN_MAX) begin
			turns_new = turns_q + TURN_BITS'(1);
		end else if (quad_new == QUAD_4 && last_quad_q == QUAD_1 && turns_q != TURN_MIN) begin
			turns_new = turns_q - TURN_BITS'(1);
		end
		pos_new   = {turns_new, corr};
		delta_new = {pos_new[POS_BITS-1], pos_new} - {last_pos_q[POS_BITS-1], last_pos_q};
		delta_neg = (POS_BITS + 1)'(0) - delta_q;
	end

	// Shared add/subtract unit; a set carry on a subtract means a >= b.
	always_comb begin
		alu_sum   = {1'b0, alu_req.a} + {1'b0, alu_req.sub ? ~alu_req.b : alu_req.b}
			+ (ALU_BITS + 1)'(alu_req.sub);
		alu_carry = alu_sum[ALU_BITS];
		mul_hi    = prod_q[0] ? alu_sum[MAG_BITS:0] : {1'b0, prod_q[PROD_BITS-1:TPS_BITS]};
		div_bit   = prod_q[DIV_STEPS-1];
	end

	always_comb begin
		quot_ext = {1'b0, prod_q[DIV_STEPS-1:0]};
		if (!vvalid_q) begin
			vel_fin = '0;
		end else if (ovf_q) begin
			vel_fin = neg_q ? VEL_MIN : VEL_MAX;
		end else if (neg_q) begin
			vel_fin = VEL_BITS'(0) - quot_ext;
		end else begin
			vel_fin = quot_ext;
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_UPD;
			ST_UPD:  state_d = has_velocity ? ST_ABS : ST_FIN;
			ST_ABS:  state_d = ST_MUL;
			ST_MUL:  if (cnt_q == CNT_BITS'(MUL_STEPS - 1)) state_d = ST_CHK;
			ST_CHK:  state_d = alu_carry ? ST_FIN : ST_DIV;
			ST_DIV:  if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs and shared unit operand selection.
	always_comb begin
		s_tready    = 1'b0;
		out_load    = 1'b0;
		alu_req.sub = 1'b0;
		alu_req.a   = '0;
		alu_req.b   = '0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_MUL: begin
				alu_req.a = ALU_BITS'(prod_q[PROD_BITS-1:TPS_BITS]);
				alu_req.b = ALU_BITS'(mag_q);
			end
			ST_CHK: begin
				alu_req.sub = 1'b1;
				alu_req.a   = ALU_BITS'(prod_q[PROD_BITS-1:DIV_STEPS]);
				alu_req.b   = ALU_BITS'(elapsed_q);
			end
			ST_DIV: begin
				alu_req.sub = 1'b1;
				alu_req.a   = ALU_BITS'({rem_q, div_bit});
				alu_req.b   = ALU_BITS'(elapsed_q);
			end
			ST_FIN:  out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			tps_q         <= TPS_RESET;
			zero_offset_q <= '0;
			last_quad_q   <= QUAD_NONE;
			turns_q       <= '0;
			last_pos_q    <= '0;
			cnt_q         <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				tps_q <= cfg_data;
			end
			if (state_q == ST_UPD) begin
				if (cmd_q == CMD_ZERO) begin
					zero_offset_q <= raw_q;
				end else begin
					last_quad_q <= quad_new;
					turns_q     <= turns_new;
					last_pos_q  <= pos_new;
				end
			end
			if (state_q == ST_MUL || state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end else begin
				cnt_q <= '0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q     <= s_tuser;
			raw_q     <= s_tdata[ANGLE_BITS-1:0];
			elapsed_q <= s_tdata[ANGLE_BITS+ELAPSED_BITS-1:ANGLE_BITS];
		end
		unique case (state_q)
			ST_UPD: begin
				delta_q  <= delta_new;
				vvalid_q <= has_velocity;
				ovf_q    <= 1'b0;
			end
			ST_ABS: begin
				neg_q  <= delta_q[POS_BITS];
				mag_q  <= delta_q[POS_BITS] ? delta_neg[MAG_BITS-1:0] : delta_q[MAG_BITS-1:0];
				prod_q <= PROD_BITS'(tps_q);
			end
			ST_MUL: prod_q <= {mul_hi, prod_q[TPS_BITS-1:1]};
			ST_CHK: begin
				ovf_q <= alu_carry;
				rem_q <= prod_q[DIV_STEPS+ELAPSED_BITS-1:DIV_STEPS];
			end
			ST_DIV: begin
				rem_q <= alu_carry ? alu_sum[ELAPSED_BITS-1:0]
					: {rem_q[ELAPSED_BITS-2:0], div_bit};
				prod_q[DIV_STEPS-1:0] <= {prod_q[DIV_STEPS-2:0], alu_carry};
			end
			default: ;
		endcase
		if (out_load) begin
			out_pos_q    <= last_pos_q;
			out_turns_q  <= turns_q;
			out_quad_q   <= last_quad_q;
			out_vel_q    <= vel_fin;
			out_vvalid_q <= vvalid_q;
		end
	end

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q == ST_UPD)
		else $error("sequencer did not start after a request");

	a_turns_only_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_UPD |=> $stable(turns_q))
		else $error("turn count changed outside the update cycle");

	a_valid_velocity_has_quadrant: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> out_quad_q != QUAD_NONE)
		else $error("valid velocity reported without a quadrant");

	a_div_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q <= CNT_BITS'(DIV_STEPS - 1))
		else $error("divide step count out of range");

endmodule
